// File: rtl/hpq_pkg.sv
// Package for the binary max-heap priority queue.
// Holds widths, opcode and status codes, payload structs and controller/datapath types.
// No dependencies.
`default_nettype none

package hpq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;

  localparam logic signed [KEY_W-1:0] KEY_TOP = 32'sh7FFF_FFFF;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_CHANGE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADIDX = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        index;
  } hpq_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        count;
  } hpq_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CK_CMP,
    S_EX_ISSUE,
    S_EX_LOAD,
    S_PK_LOAD,
    S_SU_RD,
    S_SU_CMP,
    S_SD_RD,
    S_SD_CMP,
    S_WR_FINAL,
    S_DONE
  } hpq_state_t;

  // One datapath step per cycle, chosen by the controller
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_LATCH,
    STEP_INS_INIT,
    STEP_RD_ENDS,
    STEP_EX_LOAD,
    STEP_PK_LOAD,
    STEP_RD_IDX,
    STEP_CK_LOAD,
    STEP_RD_PARENT,
    STEP_UP_MOVE,
    STEP_RD_KIDS,
    STEP_DN_MOVE,
    STEP_WR_FINAL,
    STEP_OUT_LOAD
  } hpq_step_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            at_root;
    logic            up_swap;
    logic            old_gt;
    logic            old_lt;
    logic            big_found;
  } hpq_flags_t;

endpackage

`default_nettype wire

// File: rtl/max_heap_priority_queue_top.sv
// Binary max-heap priority queue of signed 32-bit keys, 64 entries.
// Request channel (in_*): opcode insert, extract max, peek, change key, delete at index.
// Result channel (out_*): one result per request with key_out, status and count.
// Both channels move one transaction when valid and ready are high at a clock edge.
// One request is worked at a time; in_ready is high only while the controller idles.
// Flagged requests and unknown opcodes go straight to the result; peek reads the root;
// the longest request is a delete that sifts up from the last of 64 entries to the root
// and then sifts the popped heap down through five levels.
// A new request can be accepted in the same cycle that the result goes valid.
// Each heap level takes a read of the parent or both children from the heap RAM
// (registered read), then a compare that moves a key.
// The result sits in an output register; a new request is accepted while it waits.
// If the receiver stalls, a finished second request holds in the controller until
// the output register frees.
// Reset (rst_n low, synchronous) empties the heap at once; RAM contents are not cleared.
// Depends on hpq_pkg, hpq_ctrl, hpq_dp and hpq_ram.
`default_nettype none

module max_heap_priority_queue_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hpq_pkg::hpq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hpq_pkg::hpq_out_t out_data
);

  hpq_pkg::hpq_step_t  step;
  hpq_pkg::hpq_flags_t flags;

  hpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .flags    (flags),
    .step     (step)
  );

  hpq_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_data (in_data),
    .flags   (flags),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

// File: rtl/hpq_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         ra_data,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    ra_data <= mem_r[ra_addr];
    rb_data <= mem_r[rb_addr];
  end

endmodule

`default_nettype wire

// File: rtl/hpq_ctrl.sv
// Controller for the heap queue: sequences insert, extract, peek, change-key and delete.
// Depends on hpq_pkg; drives hpq_dp through one step code per cycle.
`default_nettype none

module hpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  hpq_pkg::hpq_flags_t flags,
  output hpq_pkg::hpq_step_t step
);

  hpq_pkg::hpq_state_t state_r, state_nxt;
  logic popped_r, popped_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpq_pkg::S_IDLE;
      popped_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      popped_r    <= popped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    popped_nxt    = popped_r;
    step          = hpq_pkg::STEP_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      hpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          step       = hpq_pkg::STEP_LATCH;
          popped_nxt = 1'b0;
          state_nxt  = hpq_pkg::S_DISPATCH;
        end
      end
      hpq_pkg::S_DISPATCH: begin
        if (flags.err) begin
          state_nxt = hpq_pkg::S_DONE;
        end else begin
          case (flags.op) inside
            hpq_pkg::OP_INSERT: begin
              step      = hpq_pkg::STEP_INS_INIT;
              state_nxt = hpq_pkg::S_SU_RD;
            end
            hpq_pkg::OP_EXTRACT: begin
              step      = hpq_pkg::STEP_RD_ENDS;
              state_nxt = hpq_pkg::S_EX_LOAD;
            end
            hpq_pkg::OP_PEEK: begin
              step      = hpq_pkg::STEP_RD_ENDS;
              state_nxt = hpq_pkg::S_PK_LOAD;
            end
            hpq_pkg::OP_CHANGE, hpq_pkg::OP_DELETE: begin
              step      = hpq_pkg::STEP_RD_IDX;
              state_nxt = hpq_pkg::S_CK_CMP;
            end
            default: state_nxt = hpq_pkg::S_DONE;
          endcase
        end
      end
      hpq_pkg::S_CK_CMP: begin
        if (flags.old_gt) begin
          step      = hpq_pkg::STEP_CK_LOAD;
          state_nxt = hpq_pkg::S_SD_RD;
        end else if (flags.old_lt) begin
          step      = hpq_pkg::STEP_CK_LOAD;
          state_nxt = hpq_pkg::S_SU_RD;
        end else if (flags.op == hpq_pkg::OP_DELETE) begin
          state_nxt = hpq_pkg::S_EX_ISSUE;
        end else begin
          state_nxt = hpq_pkg::S_DONE;
        end
      end
      hpq_pkg::S_EX_ISSUE: begin
        step      = hpq_pkg::STEP_RD_ENDS;
        state_nxt = hpq_pkg::S_EX_LOAD;
      end
      hpq_pkg::S_EX_LOAD: begin
        step       = hpq_pkg::STEP_EX_LOAD;
        popped_nxt = 1'b1;
        state_nxt  = hpq_pkg::S_SD_RD;
      end
      hpq_pkg::S_PK_LOAD: begin
        step      = hpq_pkg::STEP_PK_LOAD;
        state_nxt = hpq_pkg::S_DONE;
      end
      hpq_pkg::S_SU_RD: begin
        if (flags.at_root) begin
          state_nxt = hpq_pkg::S_WR_FINAL;
        end else begin
          step      = hpq_pkg::STEP_RD_PARENT;
          state_nxt = hpq_pkg::S_SU_CMP;
        end
      end
      hpq_pkg::S_SU_CMP: begin
        if (flags.up_swap) begin
          step      = hpq_pkg::STEP_UP_MOVE;
          state_nxt = hpq_pkg::S_SU_RD;
        end else begin
          state_nxt = hpq_pkg::S_WR_FINAL;
        end
      end
      hpq_pkg::S_SD_RD: begin
        step      = hpq_pkg::STEP_RD_KIDS;
        state_nxt = hpq_pkg::S_SD_CMP;
      end
      hpq_pkg::S_SD_CMP: begin
        if (flags.big_found) begin
          step      = hpq_pkg::STEP_DN_MOVE;
          state_nxt = hpq_pkg::S_SD_RD;
        end else begin
          state_nxt = hpq_pkg::S_WR_FINAL;
        end
      end
      hpq_pkg::S_WR_FINAL: begin
        step = hpq_pkg::STEP_WR_FINAL;
        // delete raises the key first, then pops the root
        if (flags.op == hpq_pkg::OP_DELETE && !popped_r) begin
          state_nxt = hpq_pkg::S_EX_ISSUE;
        end else begin
          state_nxt = hpq_pkg::S_DONE;
        end
      end
      hpq_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          step          = hpq_pkg::STEP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = hpq_pkg::S_IDLE;
        end
      end
      default: state_nxt = hpq_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/hpq_dp.sv
// Datapath for the heap queue: request registers, sift cursor, entry count, heap RAM.
// Depends on hpq_pkg and hpq_ram; steered by hpq_ctrl.
`default_nettype none

module hpq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  hpq_pkg::hpq_step_t  step,
  input  hpq_pkg::hpq_in_t    in_data,
  output hpq_pkg::hpq_flags_t flags,
  output hpq_pkg::hpq_out_t   out_data
);

  logic [hpq_pkg::OP_W-1:0]          op_r, op_nxt;
  logic signed [hpq_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [hpq_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic [hpq_pkg::STAT_W-1:0]        stat_r, stat_nxt;
  logic [hpq_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [hpq_pkg::IDX_W-1:0]         cur_r, cur_nxt;
  logic signed [hpq_pkg::KEY_W-1:0]  val_r, val_nxt;
  logic signed [hpq_pkg::KEY_W-1:0]  top_r, top_nxt;
  hpq_pkg::hpq_out_t                 out_r, out_nxt;

  logic                              we;
  logic [hpq_pkg::IDX_W-1:0]         waddr, ra_addr, rb_addr;
  logic [hpq_pkg::KEY_W-1:0]         wdata, ra_data, rb_data;

  logic signed [hpq_pkg::KEY_W-1:0]  ra_s, rb_s, cand;
  logic [hpq_pkg::IDX_W-1:0]         par_idx, last_idx;
  logic [hpq_pkg::CNT_W-1:0]         cnt_m1, left_pos;
  logic [hpq_pkg::CNT_W:0]           right_pos;
  logic                              l_big, r_big;
  logic [hpq_pkg::STAT_W-1:0]        new_stat;

  hpq_ram #(
    .WIDTH(hpq_pkg::KEY_W),
    .DEPTH(hpq_pkg::CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .ra_addr(ra_addr),
    .rb_addr(rb_addr),
    .ra_data(ra_data),
    .rb_data(rb_data)
  );

  assign ra_s      = $signed(ra_data);
  assign rb_s      = $signed(rb_data);
  assign par_idx   = (cur_r - hpq_pkg::IDX_W'(1)) >> 1;
  assign cnt_m1    = cnt_r - hpq_pkg::CNT_W'(1);
  assign last_idx  = cnt_m1[hpq_pkg::IDX_W-1:0];
  assign left_pos  = {cur_r, 1'b1};
  assign right_pos = {1'b0, cur_r, 1'b1} + (hpq_pkg::CNT_W+1)'(1);

  // pick the larger child that beats the carried key
  assign l_big = (left_pos < cnt_r) && (ra_s > val_r);
  assign cand  = l_big ? ra_s : val_r;
  assign r_big = (right_pos < {1'b0, cnt_r}) && (rb_s > cand);

  always_comb begin
    new_stat = hpq_pkg::STAT_OK;
    case (in_data.opcode) inside
      hpq_pkg::OP_INSERT:
        if (cnt_r >= hpq_pkg::CNT_W'(hpq_pkg::CAPACITY)) new_stat = hpq_pkg::STAT_FULL;
      hpq_pkg::OP_EXTRACT, hpq_pkg::OP_PEEK:
        if (cnt_r == '0) new_stat = hpq_pkg::STAT_EMPTY;
      hpq_pkg::OP_CHANGE, hpq_pkg::OP_DELETE:
        if ({1'b0, in_data.index} >= cnt_r) new_stat = hpq_pkg::STAT_BADIDX;
      default: new_stat = hpq_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    op_nxt  = op_r;
    key_nxt = key_r;
    idx_nxt = idx_r;
    stat_nxt = stat_r;
    cnt_nxt = cnt_r;
    cur_nxt = cur_r;
    val_nxt = val_r;
    top_nxt = top_r;
    out_nxt = out_r;
    we      = 1'b0;
    waddr   = cur_r;
    wdata   = val_r;
    ra_addr = '0;
    rb_addr = '0;
    unique case (step)
      hpq_pkg::STEP_NONE: begin
      end
      hpq_pkg::STEP_LATCH: begin
        op_nxt   = in_data.opcode;
        key_nxt  = (in_data.opcode == hpq_pkg::OP_DELETE) ? hpq_pkg::KEY_TOP : in_data.key;
        idx_nxt  = in_data.index;
        stat_nxt = new_stat;
      end
      hpq_pkg::STEP_INS_INIT: begin
        cur_nxt = cnt_r[hpq_pkg::IDX_W-1:0];
        val_nxt = key_r;
        cnt_nxt = cnt_r + hpq_pkg::CNT_W'(1);
      end
      hpq_pkg::STEP_RD_ENDS: begin
        ra_addr = '0;
        rb_addr = last_idx;
      end
      hpq_pkg::STEP_EX_LOAD: begin
        top_nxt = ra_s;
        val_nxt = rb_s;
        cnt_nxt = cnt_m1;
        cur_nxt = '0;
      end
      hpq_pkg::STEP_PK_LOAD: begin
        top_nxt = ra_s;
      end
      hpq_pkg::STEP_RD_IDX: begin
        rb_addr = idx_r;
      end
      hpq_pkg::STEP_CK_LOAD: begin
        val_nxt = key_r;
        cur_nxt = idx_r;
      end
      hpq_pkg::STEP_RD_PARENT: begin
        ra_addr = par_idx;
      end
      hpq_pkg::STEP_UP_MOVE: begin
        we      = 1'b1;
        wdata   = ra_data;
        cur_nxt = par_idx;
      end
      hpq_pkg::STEP_RD_KIDS: begin
        ra_addr = left_pos[hpq_pkg::IDX_W-1:0];
        rb_addr = right_pos[hpq_pkg::IDX_W-1:0];
      end
      hpq_pkg::STEP_DN_MOVE: begin
        we      = 1'b1;
        wdata   = r_big ? rb_data : ra_data;
        cur_nxt = r_big ? right_pos[hpq_pkg::IDX_W-1:0] : left_pos[hpq_pkg::IDX_W-1:0];
      end
      hpq_pkg::STEP_WR_FINAL: begin
        we = 1'b1;
      end
      hpq_pkg::STEP_OUT_LOAD: begin
        out_nxt.key_out = ((op_r == hpq_pkg::OP_EXTRACT || op_r == hpq_pkg::OP_PEEK) &&
                           stat_r == hpq_pkg::STAT_OK) ? top_r : '0;
        out_nxt.status  = stat_r;
        out_nxt.count   = cnt_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    stat_r <= stat_nxt;
    cur_r  <= cur_nxt;
    val_r  <= val_nxt;
    top_r  <= top_nxt;
    out_r  <= out_nxt;
  end

  assign flags.op        = op_r;
  assign flags.err       = (stat_r != hpq_pkg::STAT_OK);
  assign flags.at_root   = (cur_r == '0);
  assign flags.up_swap   = (ra_s < val_r);
  assign flags.old_gt    = (rb_s > key_r);
  assign flags.old_lt    = (rb_s < key_r);
  assign flags.big_found = l_big || r_big;

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: rtl/hpq_checker.sv
// Port-level checks for the heap queue, bound to max_heap_priority_queue_top.
// Depends on hpq_pkg.
`default_nettype none

module hpq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input hpq_pkg::hpq_out_t out_data
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.count <= hpq_pkg::CNT_W'(hpq_pkg::CAPACITY)))
    else $error("count above capacity");

  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != hpq_pkg::STAT_OK) |-> (out_data.key_out == '0))
    else $error("flagged result carries a key");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind max_heap_priority_queue_top hpq_checker u_hpq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
